/* design/ies_pkg.sv */
// ies_pkg: shared types and constants for the image extreme statistics block
// holds the pixel item, extreme record and report control types
// no dependencies
`default_nettype none

package ies_pkg;

   localparam int COMP_W   = 8;
   localparam int SUM_W    = 10;
   localparam int POS_W    = 12;
   localparam int CFG_W    = 13;
   localparam int KIND_W   = 3;
   localparam int NUM_KIND = 8;

   localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd640;

   typedef enum logic [KIND_W-1:0] {
      KIND_MAX_SUM,
      KIND_MIN_SUM,
      KIND_MAX_RED,
      KIND_MAX_GREEN,
      KIND_MAX_BLUE,
      KIND_MIN_RED,
      KIND_MIN_GREEN,
      KIND_MIN_BLUE
   } kind_type;

   // one pixel with the position it was given on acceptance
   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic              frame_end;
      logic [POS_W-1:0]  col;
      logic [POS_W-1:0]  row;
   } pixel_type;

   // one tracked extreme; colors stay zero for the component kinds
   typedef struct packed {
      logic [SUM_W-1:0]  value;
      logic [POS_W-1:0]  col;
      logic [POS_W-1:0]  row;
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } extreme_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
      logic     last;
   } report_ctrl_type;

endpackage

`default_nettype wire

/* design/image_extreme_statistics.sv */
// image_extreme_statistics: top level, pixel position tracking and report output
// depends on ies_pkg and ies_extremes
//
//   channel | direction | transfer moves
//   --------+-----------+-----------------------------------------------
//   req     | in        | one rgb pixel, frame_end on the last pixel
//   rsp     | out       | one extreme report, eight per frame, kinds in order
//   csr     | in        | image width, taken on any cycle write enable is high
//
// one pixel per clock is taken while no frame-end pixel waits; a pixel reaches
// the trackers in the cycle after its transfer; the eight reports leave one per
// clock from a snapshot bank through the output register while rsp_stall is
// low, so the next frame streams in while they drain; a frame-end pixel waits in
// the input register while the previous frame's bank still holds reports not
// yet transferred. reset is synchronous and active high; it restores width 640
// and empties all stages. rsp_stall holds the output register and, through the
// bank, only blocks the next frame-end pixel.
`default_nettype none

module image_extreme_statistics import ies_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [CFG_W-1:0]    csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [COMP_W-1:0]   req_red,
   input  wire logic [COMP_W-1:0]   req_green,
   input  wire logic [COMP_W-1:0]   req_blue,
   input  wire logic                req_frame_end,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [KIND_W-1:0]        rsp_report_kind,
   output logic [POS_W-1:0]         rsp_col,
   output logic [POS_W-1:0]         rsp_row,
   output logic [COMP_W-1:0]        rsp_pix_red,
   output logic [COMP_W-1:0]        rsp_pix_green,
   output logic [COMP_W-1:0]        rsp_pix_blue,
   output logic [SUM_W-1:0]         rsp_extreme_value,
   output logic                     rsp_last_report
);

   // counter width for positions up to MAX_DIM-1
   localparam int CNT_W = $clog2(MAX_DIM);
   // compare width: holds the register value and MAX_DIM itself
   localparam int CMP_W = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;

   // configuration
   logic [CFG_W-1:0]  width_ff, width_in;
   logic [CMP_W-1:0]  width_ext;
   logic [CMP_W-1:0]  width_eff;

   // raster position of the next pixel
   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic              col_wrap;

   // input register
   logic              req_accept;
   logic              s1_valid_ff, s1_valid_in;
   pixel_type         s1_item_ff, s1_item_in;
   logic              item_take;

   // report path
   report_ctrl_type   rpt_ctrl;
   extreme_type       rpt_data;
   logic              rpt_pop;
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff;
   extreme_type       rsp_data_ff;
   logic              rsp_last_ff;

   assign width_in = csr_write_enable ? csr_write_data : width_ff;

   // zero width counts as one, anything above MAX_DIM as MAX_DIM
   always_comb begin
      width_ext = CMP_W'(width_ff);
      if (width_ext == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_DIM)) begin
         width_eff = CMP_W'(MAX_DIM);
      end else begin
         width_eff = width_ext;
      end
   end

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = s1_valid_ff && !item_take;
   assign col_wrap   = (CMP_W'(col_ff) + CMP_W'(1)) >= width_eff;

   // position update, frame end restarts at the origin
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (req_frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            // row saturates at the top of its range
            if (row_ff < CNT_W'(MAX_DIM - 1)) begin
               row_in = row_ff + CNT_W'(1);
            end
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      s1_item_in.red       = req_red;
      s1_item_in.green     = req_green;
      s1_item_in.blue      = req_blue;
      s1_item_in.frame_end = req_frame_end;
      s1_item_in.col       = POS_W'(col_ff);
      s1_item_in.row       = POS_W'(row_ff);
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (item_take) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= s1_item_in;
      end
   end

   ies_extremes u_extremes (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .item       (s1_item_ff),
      .item_take  (item_take),
      .rpt_ctrl   (rpt_ctrl),
      .rpt_data   (rpt_data),
      .rpt_pop    (rpt_pop)
   );

   // output register refills whenever it is empty or being transferred
   assign rpt_pop = rpt_ctrl.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (rpt_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rpt_pop) begin
         rsp_kind_ff <= rpt_ctrl.kind;
         rsp_last_ff <= rpt_ctrl.last;
         rsp_data_ff <= rpt_data;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_report_kind   = rsp_kind_ff;
   assign rsp_col           = rsp_data_ff.col;
   assign rsp_row           = rsp_data_ff.row;
   assign rsp_pix_red       = rsp_data_ff.red;
   assign rsp_pix_green     = rsp_data_ff.green;
   assign rsp_pix_blue      = rsp_data_ff.blue;
   assign rsp_extreme_value = rsp_data_ff.value;
   assign rsp_last_report   = rsp_last_ff;

endmodule

`default_nettype wire

/* design/ies_extremes.sv */
// ies_extremes: eight extreme trackers and the frame report bank
// depends on ies_pkg
`default_nettype none

module ies_extremes import ies_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            item_valid,
   input  wire pixel_type       item,
   output logic                 item_take,
   output report_ctrl_type      rpt_ctrl,
   output extreme_type          rpt_data,
   input  wire logic            rpt_pop
);

   // bit per kind: 1 keeps the largest value, 0 the smallest
   localparam logic [NUM_KIND-1:0] IS_MAX = 8'b0001_1101;

   logic                 started_ff, started_in;
   logic                 bank_valid_ff, bank_valid_in;
   logic [KIND_W-1:0]    bank_idx_ff, bank_idx_in;
   extreme_type          trk_ff  [NUM_KIND];
   extreme_type          trk_in  [NUM_KIND];
   extreme_type          bank_ff [NUM_KIND];
   extreme_type          cand    [NUM_KIND];
   logic [SUM_W-1:0]     sum;
   logic                 better;

   assign item_take = item_valid && (!item.frame_end || !bank_valid_ff);

   always_comb begin
      sum = SUM_W'(item.red) + SUM_W'(item.green) + SUM_W'(item.blue);
      for (int k = 0; k < NUM_KIND; k++) begin
         cand[k] = '{value: '0, col: item.col, row: item.row,
                     red: '0, green: '0, blue: '0};
      end
      cand[KIND_MAX_SUM].value = sum;
      cand[KIND_MIN_SUM].value = sum;
      for (int k = 0; k < 2; k++) begin
         cand[k].red   = item.red;
         cand[k].green = item.green;
         cand[k].blue  = item.blue;
      end
      cand[KIND_MAX_RED].value   = SUM_W'(item.red);
      cand[KIND_MAX_GREEN].value = SUM_W'(item.green);
      cand[KIND_MAX_BLUE].value  = SUM_W'(item.blue);
      cand[KIND_MIN_RED].value   = SUM_W'(item.red);
      cand[KIND_MIN_GREEN].value = SUM_W'(item.green);
      cand[KIND_MIN_BLUE].value  = SUM_W'(item.blue);

      for (int k = 0; k < NUM_KIND; k++) begin
         better = IS_MAX[k] ? (cand[k].value > trk_ff[k].value)
                            : (cand[k].value < trk_ff[k].value);
         // first pixel of a frame seeds, ties keep the earlier pixel
         trk_in[k] = (!started_ff || better) ? cand[k] : trk_ff[k];
      end
   end

   always_comb begin
      started_in    = started_ff;
      bank_valid_in = bank_valid_ff;
      bank_idx_in   = bank_idx_ff;
      if (item_take) begin
         started_in = !item.frame_end;
         if (item.frame_end) begin
            bank_valid_in = 1'b1;
         end
      end
      if (rpt_pop) begin
         bank_idx_in = bank_idx_ff + KIND_W'(1);
         if (bank_idx_ff == KIND_MIN_BLUE) begin
            bank_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         bank_valid_ff <= 1'b0;
         bank_idx_ff   <= '0;
      end else begin
         started_ff    <= started_in;
         bank_valid_ff <= bank_valid_in;
         bank_idx_ff   <= bank_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         trk_ff <= trk_in;
         if (item.frame_end) begin
            bank_ff <= trk_in;
         end
      end
   end

   assign rpt_ctrl.valid = bank_valid_ff;
   assign rpt_ctrl.kind  = kind_type'(bank_idx_ff);
   assign rpt_ctrl.last  = (bank_idx_ff == KIND_MIN_BLUE);
   assign rpt_data       = bank_ff[bank_idx_ff];

endmodule

`default_nettype wire

/* design/ies_checker.sv */
// ies_checker: port-level checks on the report stream of the top level
// depends on ies_pkg; bound to image_extreme_statistics at the end of this file
`default_nettype none

module ies_checker import ies_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [KIND_W-1:0]   rsp_report_kind,
   input wire logic [COMP_W-1:0]   rsp_pix_red,
   input wire logic [COMP_W-1:0]   rsp_pix_green,
   input wire logic [COMP_W-1:0]   rsp_pix_blue,
   input wire logic                rsp_last_report
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("report valid right after reset");

   // last flag only on the final kind
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_report == (rsp_report_kind == KIND_MIN_BLUE)))
      else $error("last flag does not match the final kind");

   // reports of a frame follow back to back in kind order
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_report) |=>
         (rsp_valid && rsp_report_kind == $past(rsp_report_kind) + KIND_W'(1)))
      else $error("report sequence broken");

   // component kinds carry no pixel colors
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_report_kind != KIND_MAX_SUM && rsp_report_kind != KIND_MIN_SUM)
         |-> (rsp_pix_red == '0 && rsp_pix_green == '0 && rsp_pix_blue == '0))
      else $error("colors on a component report");

   // a stalled report holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_report_kind)))
      else $error("stalled report changed");

endmodule

bind image_extreme_statistics ies_checker u_ies_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_report_kind (rsp_report_kind),
   .rsp_pix_red     (rsp_pix_red),
   .rsp_pix_green   (rsp_pix_green),
   .rsp_pix_blue    (rsp_pix_blue),
   .rsp_last_report (rsp_last_report)
);

`default_nettype wire

/* tb/sv/testbench.sv */
// testbench: self-checking bench for the image_extreme_statistics block
// predicts the eight extreme reports of every frame and checks each rsp transfer
// depends on ies_pkg and the image_extreme_statistics rtl
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ies_pkg::*;

   localparam int DIM_LIMIT    = 4096;
   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 6;
   localparam int MAX_SHOWN    = 10;

   // one report as it leaves the rsp channel
   typedef struct packed {
      kind_type          kind;
      logic [POS_W-1:0]  col;
      logic [POS_W-1:0]  row;
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic [SUM_W-1:0]  value;
      logic              last;
   } report_type;

   // tracks the extremes of the open frame and holds the reports still owed
   class frame_extremes;
      logic [CFG_W-1:0]  image_width;
      int                col_count;
      int                row_count;
      bit                started;
      logic [SUM_W-1:0]  sum_value [2];
      logic [COMP_W-1:0] sum_red [2];
      logic [COMP_W-1:0] sum_green [2];
      logic [COMP_W-1:0] sum_blue [2];
      logic [POS_W-1:0]  sum_col [2];
      logic [POS_W-1:0]  sum_row [2];
      logic [COMP_W-1:0] comp_value [6];
      logic [POS_W-1:0]  comp_col [6];
      logic [POS_W-1:0]  comp_row [6];
      report_type        pending_reports [$];
      int                mismatch_count;

      function new();
         image_width    = WIDTH_RESET;
         mismatch_count = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         col_count = 0;
         row_count = 0;
         started   = 1'b0;
         for (int k = 0; k < 2; k++) begin
            sum_value[k] = '0;
            sum_red[k]   = '0;
            sum_green[k] = '0;
            sum_blue[k]  = '0;
            sum_col[k]   = '0;
            sum_row[k]   = '0;
         end
         for (int k = 0; k < 6; k++) begin
            comp_value[k] = '0;
            comp_col[k]   = '0;
            comp_row[k]   = '0;
         end
      endfunction

      function void set_width(logic [CFG_W-1:0] w);
         image_width = w;
      endfunction

      function void record_sum(int slot, logic [SUM_W-1:0] total,
                               logic [COMP_W-1:0] r, g, b);
         sum_value[slot] = total;
         sum_red[slot]   = r;
         sum_green[slot] = g;
         sum_blue[slot]  = b;
         sum_col[slot]   = POS_W'(col_count);
         sum_row[slot]   = POS_W'(row_count);
      endfunction

      function void take_pixel(logic [COMP_W-1:0] r, g, b, logic fe);
         logic [COMP_W-1:0] comp [3];
         logic [SUM_W-1:0]  total;
         int                span;
         int                k;
         report_type        rep;
         comp[0] = r;
         comp[1] = g;
         comp[2] = b;
         total   = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
         // strict compares, so ties keep the earlier pixel
         if (!started || total > sum_value[0]) record_sum(0, total, r, g, b);
         if (!started || total < sum_value[1]) record_sum(1, total, r, g, b);
         for (k = 0; k < 3; k++) begin
            if (!started || comp[k] > comp_value[k]) begin
               comp_value[k] = comp[k];
               comp_col[k]   = POS_W'(col_count);
               comp_row[k]   = POS_W'(row_count);
            end
            if (!started || comp[k] < comp_value[k+3]) begin
               comp_value[k+3] = comp[k];
               comp_col[k+3]   = POS_W'(col_count);
               comp_row[k+3]   = POS_W'(row_count);
            end
         end
         started = 1'b1;
         // zero width acts as one, oversize width is clamped
         span = image_width;
         if (span == 0) span = 1;
         if (span > DIM_LIMIT) span = DIM_LIMIT;
         if (col_count + 1 >= span) begin
            col_count = 0;
            if (row_count < DIM_LIMIT - 1) row_count++;
         end else begin
            col_count++;
         end
         if (fe) begin
            for (k = 0; k < NUM_KIND; k++) begin
               rep.kind = kind_type'(k);
               rep.last = (k == NUM_KIND - 1);
               if (k < 2) begin
                  rep.col   = sum_col[k];
                  rep.row   = sum_row[k];
                  rep.red   = sum_red[k];
                  rep.green = sum_green[k];
                  rep.blue  = sum_blue[k];
                  rep.value = sum_value[k];
               end else begin
                  rep.col   = comp_col[k-2];
                  rep.row   = comp_row[k-2];
                  rep.red   = '0;
                  rep.green = '0;
                  rep.blue  = '0;
                  rep.value = SUM_W'(comp_value[k-2]);
               end
               pending_reports.push_back(rep);
            end
            clear_frame();
         end
      endfunction

      function string describe(report_type rep);
         return $sformatf("kind %0d col %0d row %0d rgb %0d/%0d/%0d value %0d last %0d",
                          rep.kind, rep.col, rep.row, rep.red, rep.green, rep.blue,
                          rep.value, rep.last);
      endfunction

      function void note_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= MAX_SHOWN) $display("mismatch: %s", msg);
      endfunction

      function void check_report(report_type got);
         report_type want;
         if (pending_reports.size() == 0) begin
            note_mismatch({"report with none expected: ", describe(got)});
            return;
         end
         want = pending_reports.pop_front();
         if (got.kind !== want.kind || got.col !== want.col || got.row !== want.row ||
             got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.value !== want.value ||
             got.last !== want.last)
            note_mismatch({"expected ", describe(want), " got ", describe(got)});
      endfunction
   endclass

   // clock, reset and every block input start at known values
   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [CFG_W-1:0]  csr_write_data   = '0;
   logic              req_valid        = 1'b0;
   logic [COMP_W-1:0] req_red          = '0;
   logic [COMP_W-1:0] req_green        = '0;
   logic [COMP_W-1:0] req_blue         = '0;
   logic              req_frame_end    = 1'b0;
   logic              rsp_stall        = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic [KIND_W-1:0] rsp_report_kind;
   logic [POS_W-1:0]  rsp_col;
   logic [POS_W-1:0]  rsp_row;
   logic [COMP_W-1:0] rsp_pix_red;
   logic [COMP_W-1:0] rsp_pix_green;
   logic [COMP_W-1:0] rsp_pix_blue;
   logic [SUM_W-1:0]  rsp_extreme_value;
   logic              rsp_last_report;

   frame_extremes     extremes = new();
   report_type        observed;
   logic [23:0]       recent_pixel = '0;
   bit                steady_phase = 1'b0;   // no gaps and no stalls at all
   int                stall_left   = 0;
   int                flow_left    = 0;
   int                cycle_count  = 0;

   image_extreme_statistics #(.MAX_DIM(DIM_LIMIT)) uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_report_kind   (rsp_report_kind),
      .rsp_col           (rsp_col),
      .rsp_row           (rsp_row),
      .rsp_pix_red       (rsp_pix_red),
      .rsp_pix_green     (rsp_pix_green),
      .rsp_pix_blue      (rsp_pix_blue),
      .rsp_extreme_value (rsp_extreme_value),
      .rsp_last_report   (rsp_last_report)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // idle length: mostly none or short, now and then a long one
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // components lean toward the range ends and small values so ties happen often
   function automatic logic [COMP_W-1:0] pick_component();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return COMP_W'($urandom_range(0, 255));
         5:             return '0;
         6:             return '1;
         7:             return ($urandom_range(0, 1) == 0) ? COMP_W'(1) : COMP_W'(254);
         default:       return COMP_W'($urandom_range(0, 3));
      endcase
   endfunction

   // widths: mostly small so rows wrap, plus zero, clamp and full register range
   function automatic logic [CFG_W-1:0] pick_width();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CFG_W'(DIM_LIMIT);
         2:       return '1;
         3, 4:    return CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
         default: return CFG_W'($urandom_range(1, 12));
      endcase
   endfunction

   // rsp side back-pressure, changed on the falling edge
   always @(negedge clock) begin
      if (steady_phase) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (flow_left > 0) begin
         rsp_stall <= 1'b0;
         flow_left--;
      end else begin
         rsp_stall <= 1'b0;
         flow_left  = $urandom_range(0, 12);
         stall_left = gap_length();
      end
   end

   // every rsp transfer is checked against the oldest expected report
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         observed.kind  = kind_type'(rsp_report_kind);
         observed.col   = rsp_col;
         observed.row   = rsp_row;
         observed.red   = rsp_pix_red;
         observed.green = rsp_pix_green;
         observed.blue  = rsp_pix_blue;
         observed.value = rsp_extreme_value;
         observed.last  = rsp_last_report;
         extremes.check_report(observed);
      end
   end

   // one pixel transfer; entered and left just after a falling edge
   task automatic send_pixel(logic [COMP_W-1:0] r, g, b, logic fe);
      int idle;
      idle = steady_phase ? 0 : gap_length();
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_red       <= r;
      req_green     <= g;
      req_blue      <= b;
      req_frame_end <= fe;
      do @(posedge clock); while (req_stall);
      extremes.take_pixel(r, g, b, fe);
      @(negedge clock);
   endtask

   task automatic send_random_pixel(logic fe);
      logic [COMP_W-1:0] r, g, b;
      // sometimes repeat the previous pixel to force exact ties
      if ($urandom_range(0, 9) == 0) begin
         {r, g, b} = recent_pixel;
      end else begin
         r = pick_component();
         g = pick_component();
         b = pick_component();
      end
      recent_pixel = {r, g, b};
      send_pixel(r, g, b, fe);
   endtask

   // drop valid, let every owed report out, then let the pipeline settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (extremes.pending_reports.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_width(logic [CFG_W-1:0] w);
      csr_write_enable <= 1'b1;
      csr_write_data   <= w;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      extremes.set_width(w);
   endtask

   initial begin : stimulus
      int random_items;
      int frames;
      int len;
      random_items = 0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset width: equal max and min pixels repeat, the first ones must win
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      // a frame of one pixel seeds every tracker
      send_pixel(8'd17, 8'd200, 8'd3, 1'b1);

      // zero width acts as one pixel per row
      wait_idle();
      write_width('0);
      send_pixel(8'd10, 8'd20, 8'd30, 1'b0);
      send_pixel(8'd9, 8'd21, 8'd29, 1'b0);
      send_pixel(8'd10, 8'd20, 8'd31, 1'b1);

      // component extremes spread over the first three pixels; later equal values lose
      wait_idle();
      write_width(CFG_W'(3));
      send_pixel(8'd255, 8'd0, 8'd128, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd1, 8'd2, 8'd3, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd0, 1'b1);

      // width shrinks mid-frame while the column is already past the new row end
      wait_idle();
      write_width(CFG_W'(5));
      send_pixel(8'd100, 8'd100, 8'd100, 1'b0);
      send_pixel(8'd50, 8'd50, 8'd50, 1'b0);
      send_pixel(8'd200, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd9, 1'b0);
      wait_idle();
      write_width(CFG_W'(2));
      send_pixel(8'd7, 8'd7, 8'd7, 1'b0);
      send_pixel(8'd254, 8'd1, 8'd1, 1'b0);
      send_pixel(8'd3, 8'd3, 8'd3, 1'b1);

      // random phases, each under a fresh width; some leave a frame open
      // so the next width takes effect mid-frame
      while (random_items < RANDOM_ITEMS) begin
         wait_idle();
         steady_phase = ($urandom_range(0, 4) == 0);
         write_width(pick_width());
         frames = $urandom_range(1, 4);
         for (int f = 0; f < frames; f++) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 60)
                                              : $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
               send_random_pixel(i == len - 1);
               random_items++;
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
               send_random_pixel(1'b0);
               random_items++;
            end
         end
      end

      steady_phase = 1'b0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (extremes.mismatch_count == 0 && extremes.pending_reports.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // hard stop if the handshakes ever hang
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
design/ies_pkg.sv
design/ies_extremes.sv
design/image_extreme_statistics.sv
design/ies_checker.sv
tb/sv/testbench.sv
